/* rtl/core/qslp_pkg.sv */
// Shared types, constants and the arctangent table of the quaternion slerp pipeline.
// Used by every module under rtl/core; depends on nothing.
package qslp_pkg;

    localparam int COMP_BITS    = 16;
    localparam int BLEND_BITS   = 17;
    localparam int THR_BITS     = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ROOT_BITS    = 29;
    localparam int QUOT_BITS    = 29;
    localparam int WIDE         = 34;
    localparam int PROD_BITS    = 2 * COMP_BITS;
    localparam int RAD_BITS     = 57;

    localparam logic [BLEND_BITS-1:0] BLEND_ONE = 17'h10000;
    localparam logic [QUOT_BITS-1:0]  WEIGHT_ONE = 29'h1000_0000;
    localparam logic [WIDE-1:0]       GAIN_K    = 34'd163008219;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef logic signed [COMP_BITS-1:0] comp_t;
    typedef logic signed [WIDE-1:0]      wide_t;

    typedef struct packed {
        comp_t [3:0]             qa;
        comp_t [3:0]             qb;
        logic [BLEND_BITS-1:0]   blend;
        logic                    flip;
        logic                    linear;
        logic [ROOT_BITS-1:0]    cosv;
        logic [ROOT_BITS-1:0]    sinv;
    } side_t;

endpackage

/* rtl/core/quaternion_slerp.sv */
// Top level of the fixed-point quaternion slerp pipeline with the weight combine stages.
// Depends on qslp_pkg, qslp_front, qslp_sqrt, qslp_atan, qslp_sin and qslp_div.
//
//   Channel  Direction  Handshake              Payload
//   s_       in         s_valid / s_ready      first_x..w, second_x..w, blend
//   m_       out        m_valid / m_ready      out_x..w, linear_path
//   cfg_     in         cfg_valid / cfg_ready  near_threshold
//
// One transaction per clock is accepted unless the output stalls; pipeline depth is
// set by the bit-per-stage square root and dividers and the two CORDIC chains.
// Reset is synchronous and active low; it empties the pipeline and sets
// near_threshold to 1. When m_ready is low with a result waiting, the whole
// pipeline holds and s_ready drops; nothing is lost or repeated.
module quaternion_slerp import qslp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  comp_t                 s_first_x,
    input  comp_t                 s_first_y,
    input  comp_t                 s_first_z,
    input  comp_t                 s_first_w,
    input  comp_t                 s_second_x,
    input  comp_t                 s_second_y,
    input  comp_t                 s_second_z,
    input  comp_t                 s_second_w,
    input  logic [BLEND_BITS-1:0] s_blend,
    output logic                  m_valid,
    input  logic                  m_ready,
    output comp_t                 m_out_x,
    output comp_t                 m_out_y,
    output comp_t                 m_out_z,
    output comp_t                 m_out_w,
    output logic                  m_linear_path,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THR_BITS-1:0]   cfg_near_threshold
);

    logic                en;
    logic [THR_BITS-1:0] thr_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 16'd1;
        end else if (cfg_valid) begin
            thr_reg <= cfg_near_threshold;
        end
    end

    logic                 fr_valid, sq_valid, at_valid, sn_valid, dv_valid;
    side_t                fr_side, sq_side, at_in_side, at_side, sn_side, dv_side;
    logic [RAD_BITS-1:0]  fr_rad;
    wide_t                theta, sin_a, sin_b;
    logic [QUOT_BITS-1:0] w_a, w_b;

    qslp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .qa_in     ({s_first_w, s_first_z, s_first_y, s_first_x}),
        .qb_in     ({s_second_w, s_second_z, s_second_y, s_second_x}),
        .blend_in  (s_blend),
        .thr       (thr_reg),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_rad   (fr_rad)
    );

    qslp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side)
    );

    always_comb begin
        at_in_side        = sq_side;
        at_in_side.linear = sq_side.linear || (sq_side.sinv == '0);
    end

    qslp_atan u_atan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (at_in_side),
        .out_valid (at_valid),
        .out_side  (at_side),
        .out_theta (theta)
    );

    qslp_sin u_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (at_valid),
        .in_side   (at_side),
        .in_theta  (theta),
        .out_valid (sn_valid),
        .out_side  (sn_side),
        .out_sin_a (sin_a),
        .out_sin_b (sin_b)
    );

    qslp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sn_valid),
        .in_side   (sn_side),
        .in_num_a  (sin_a),
        .in_num_b  (sin_b),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_w_a   (w_a),
        .out_w_b   (w_b)
    );

    // Weight select and sign, then products, then rounding and saturation.
    logic                 c1_valid_reg, c2_valid_reg;
    side_t                c1_side_reg;
    logic signed [29:0]   wa1_reg, wb1_reg;
    logic                 lin2_reg;
    logic signed [45:0]   pa2_reg [4];
    logic signed [45:0]   pb2_reg [4];
    logic [QUOT_BITS-1:0] wa_sel, wb_sel;
    logic [QUOT_BITS-1:0] t_sh, tc_sh;
    comp_t                out_next [4];

    always_comb begin
        t_sh   = {dv_side.blend, 12'b0};
        tc_sh  = {17'(BLEND_ONE - dv_side.blend), 12'b0};
        wa_sel = dv_side.linear ? t_sh : w_a;
        wb_sel = dv_side.linear ? tc_sh : w_b;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic signed [46:0] acc;
            logic signed [18:0] r;
            acc = 47'(pa2_reg[i]) + 47'(pb2_reg[i]) + 47'sd134217728;
            r   = 19'(acc >>> 28);
            if (r > 19'sd32767) begin
                out_next[i] = 16'sh7FFF;
            end else if (r < -19'sd32768) begin
                out_next[i] = 16'sh8000;
            end else begin
                out_next[i] = r[COMP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else if (en) begin
            c1_valid_reg <= dv_valid;
            c2_valid_reg <= c1_valid_reg;
            m_valid      <= c2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_side_reg <= dv_side;
            wa1_reg     <= dv_side.flip ? -$signed({1'b0, wa_sel}) : $signed({1'b0, wa_sel});
            wb1_reg     <= $signed({1'b0, wb_sel});
            lin2_reg    <= c1_side_reg.linear;
            for (int i = 0; i < 4; i++) begin
                pa2_reg[i] <= $signed(c1_side_reg.qa[i]) * wa1_reg;
                pb2_reg[i] <= $signed(c1_side_reg.qb[i]) * wb1_reg;
            end
            m_out_x       <= out_next[0];
            m_out_y       <= out_next[1];
            m_out_z       <= out_next[2];
            m_out_w       <= out_next[3];
            m_linear_path <= lin2_reg;
        end
    end

endmodule

/* rtl/core/qslp_front.sv */
// Front end: dot product, sign fold, near-parallel test and the radicand 1 - cos^2.
// Depends on qslp_pkg.
module qslp_front import qslp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  comp_t [3:0]           qa_in,
    input  comp_t [3:0]           qb_in,
    input  logic [BLEND_BITS-1:0] blend_in,
    input  logic [THR_BITS-1:0]   thr,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [RAD_BITS-1:0]   out_rad
);

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    comp_t [3:0]                 qa1_reg, qa2_reg, qa3_reg, qa4_reg;
    comp_t [3:0]                 qb1_reg, qb2_reg, qb3_reg, qb4_reg;
    logic [BLEND_BITS-1:0]       t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [PROD_BITS-1:0] prod1_reg [4];
    logic [32:0]                 mag2_reg;
    logic                        flip2_reg, flip3_reg, flip4_reg;
    logic                        lin3_reg, lin4_reg;
    logic [ROOT_BITS-1:0]        cos3_reg, cos4_reg;
    logic [RAD_BITS-1:0]         sq3_reg;
    logic [RAD_BITS-1:0]         rad4_reg;

    logic [BLEND_BITS-1:0]       t1_next;
    wide_t                       dot_next;
    logic [32:0]                 mag2_next;
    logic signed [34:0]          diff_next;
    logic                        lin3_next;

    always_comb begin
        t1_next   = (blend_in > BLEND_ONE) ? BLEND_ONE : blend_in;
        dot_next  = '0;
        for (int i = 0; i < 4; i++) begin
            dot_next = dot_next + {{(WIDE-PROD_BITS){prod1_reg[i][PROD_BITS-1]}}, prod1_reg[i]};
        end
        mag2_next = dot_next[WIDE-1] ? 33'(-dot_next) : dot_next[32:0];
        diff_next = $signed({2'b00, 33'h1000_0000}) - $signed({2'b00, mag2_reg});
        lin3_next = diff_next < $signed({7'b0, thr, 12'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qa1_reg <= qa_in;
            qb1_reg <= qb_in;
            t1_reg  <= t1_next;
            for (int i = 0; i < 4; i++) begin
                prod1_reg[i] <= $signed(qa_in[i]) * $signed(qb_in[i]);
            end
            qa2_reg   <= qa1_reg;
            qb2_reg   <= qb1_reg;
            t2_reg    <= t1_reg;
            mag2_reg  <= mag2_next;
            flip2_reg <= dot_next[WIDE-1];
            qa3_reg   <= qa2_reg;
            qb3_reg   <= qb2_reg;
            t3_reg    <= t2_reg;
            flip3_reg <= flip2_reg;
            lin3_reg  <= lin3_next;
            cos3_reg  <= mag2_reg[ROOT_BITS-1:0];
            sq3_reg   <= RAD_BITS'(mag2_reg[ROOT_BITS-1:0]) * RAD_BITS'(mag2_reg[ROOT_BITS-1:0]);
            qa4_reg   <= qa3_reg;
            qb4_reg   <= qb3_reg;
            t4_reg    <= t3_reg;
            flip4_reg <= flip3_reg;
            lin4_reg  <= lin3_reg;
            cos4_reg  <= cos3_reg;
            rad4_reg  <= {1'b1, 56'b0} - sq3_reg;
        end
    end

    assign out_valid       = v4_reg;
    assign out_rad         = rad4_reg;
    assign out_side.qa     = qa4_reg;
    assign out_side.qb     = qb4_reg;
    assign out_side.blend  = t4_reg;
    assign out_side.flip   = flip4_reg;
    assign out_side.linear = lin4_reg;
    assign out_side.cosv   = cos4_reg;
    assign out_side.sinv   = '0;

endmodule

/* rtl/core/qslp_sqrt.sv */
// Pipelined integer square root, one result bit per stage, giving sin(theta) in Q.28.
// Depends on qslp_pkg.
module qslp_sqrt import qslp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  side_t               in_side,
    input  logic [RAD_BITS-1:0] in_rad,
    output logic                out_valid,
    output side_t               out_side
);

    logic                 valid_reg [ROOT_BITS+1];
    side_t                side_reg  [ROOT_BITS+1];
    logic [57:0]          num_reg   [ROOT_BITS+1];
    logic [31:0]          rem_reg   [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] root_reg  [ROOT_BITS+1];

    assign valid_reg[0] = in_valid;
    assign side_reg[0]  = in_side;
    assign num_reg[0]   = {1'b0, in_rad};
    assign rem_reg[0]   = '0;
    assign root_reg[0]  = '0;

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_step
        logic [31:0]          rem_sh;
        logic [31:0]          trial;
        logic                 take;
        logic [31:0]          rem_next;
        logic [ROOT_BITS-1:0] root_next;

        always_comb begin
            rem_sh    = {rem_reg[g][29:0], num_reg[g][57:56]};
            trial     = {1'b0, root_reg[g], 2'b01};
            take      = rem_sh >= trial;
            rem_next  = take ? rem_sh - trial : rem_sh;
            root_next = {root_reg[g][ROOT_BITS-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[g+1] <= side_reg[g];
                num_reg[g+1]  <= {num_reg[g][55:0], 2'b00};
                rem_reg[g+1]  <= rem_next;
                root_reg[g+1] <= root_next;
            end
        end
    end

    always_comb begin
        out_side      = side_reg[ROOT_BITS];
        out_side.sinv = root_reg[ROOT_BITS];
    end
    assign out_valid = valid_reg[ROOT_BITS];

endmodule

/* rtl/core/qslp_atan.sv */
// Pipelined CORDIC in vectoring mode: theta = atan2(sin, cos) in Q2.30 radians.
// Depends on qslp_pkg.
module qslp_atan import qslp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  side_t in_side,
    output logic  out_valid,
    output side_t out_side,
    output wide_t out_theta
);

    logic  valid_reg [CORDIC_STEPS+1];
    side_t side_reg  [CORDIC_STEPS+1];
    wide_t x_reg     [CORDIC_STEPS+1];
    wide_t y_reg     [CORDIC_STEPS+1];
    wide_t z_reg     [CORDIC_STEPS+1];

    assign valid_reg[0] = in_valid;
    assign side_reg[0]  = in_side;
    assign x_reg[0]     = {{(WIDE-ROOT_BITS){1'b0}}, in_side.cosv};
    assign y_reg[0]     = {{(WIDE-ROOT_BITS){1'b0}}, in_side.sinv};
    assign z_reg[0]     = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        wide_t xs, ys, ang;

        always_comb begin
            xs  = x_reg[g] >>> g;
            ys  = y_reg[g] >>> g;
            ang = {2'b00, ATAN_TAB[g]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[g+1] <= side_reg[g];
                if (y_reg[g] > 0) begin
                    x_reg[g+1] <= x_reg[g] + ys;
                    y_reg[g+1] <= y_reg[g] - xs;
                    z_reg[g+1] <= z_reg[g] + ang;
                end else begin
                    x_reg[g+1] <= x_reg[g] - ys;
                    y_reg[g+1] <= y_reg[g] + xs;
                    z_reg[g+1] <= z_reg[g] - ang;
                end
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];
    assign out_theta = z_reg[CORDIC_STEPS];

endmodule

/* rtl/core/qslp_sin.sv */
// Splits theta into t*theta and (1-t)*theta and runs two rotation-mode CORDIC sines.
// Depends on qslp_pkg.
module qslp_sin import qslp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  side_t in_side,
    input  wide_t in_theta,
    output logic  out_valid,
    output side_t out_side,
    output wide_t out_sin_a,
    output wide_t out_sin_b
);

    logic               va_reg, vb_reg;
    side_t              sa_reg, sb_reg;
    logic signed [51:0] prod_reg;
    wide_t              theta_reg;
    wide_t              ang_a;

    assign ang_a = prod_reg[WIDE+15:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg    <= in_side;
            prod_reg  <= $signed({1'b0, in_side.blend}) * in_theta;
            theta_reg <= in_theta;
            sb_reg    <= sa_reg;
        end
    end

    logic  valid_reg [CORDIC_STEPS+1];
    side_t side_reg  [CORDIC_STEPS+1];
    wide_t x_reg     [2][CORDIC_STEPS+1];
    wide_t y_reg     [2][CORDIC_STEPS+1];
    wide_t z_reg     [2][CORDIC_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0][0] <= ang_a;
            z_reg[1][0] <= theta_reg - ang_a;
        end
    end

    assign valid_reg[0] = vb_reg;
    assign side_reg[0]  = sb_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign x_reg[l][0] = GAIN_K;
        assign y_reg[l][0] = '0;

        for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
            wide_t xs, ys, ang;

            always_comb begin
                xs  = x_reg[l][g] >>> g;
                ys  = y_reg[l][g] >>> g;
                ang = {2'b00, ATAN_TAB[g]};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (z_reg[l][g] >= 0) begin
                        x_reg[l][g+1] <= x_reg[l][g] - ys;
                        y_reg[l][g+1] <= y_reg[l][g] + xs;
                        z_reg[l][g+1] <= z_reg[l][g] - ang;
                    end else begin
                        x_reg[l][g+1] <= x_reg[l][g] + ys;
                        y_reg[l][g+1] <= y_reg[l][g] - xs;
                        z_reg[l][g+1] <= z_reg[l][g] + ang;
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];
    assign out_sin_a = y_reg[0][CORDIC_STEPS];
    assign out_sin_b = y_reg[1][CORDIC_STEPS];

endmodule

/* rtl/core/qslp_div.sv */
// Two pipelined restoring dividers giving the weights sin(angle) / sin(theta) in Q.28.
// Depends on qslp_pkg.
module qslp_div import qslp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  wide_t                in_num_a,
    input  wide_t                in_num_b,
    output logic                 out_valid,
    output side_t                out_side,
    output logic [QUOT_BITS-1:0] out_w_a,
    output logic [QUOT_BITS-1:0] out_w_b
);

    logic                 valid_reg [QUOT_BITS+3];
    side_t                side_reg  [QUOT_BITS+3];
    logic [30:0]          rem_reg   [2][QUOT_BITS+1];
    logic [QUOT_BITS-1:0] quo_reg   [2][QUOT_BITS+1];
    logic                 zero_reg  [2][QUOT_BITS+1];
    logic                 over_reg  [2][QUOT_BITS+1];
    logic [QUOT_BITS-1:0] w_reg     [2];
    wide_t                num [2];

    function automatic logic [30:0] den_at(input int g);
        return {2'b00, side_reg[g+1].sinv};
    endfunction

    assign valid_reg[0] = in_valid;
    assign side_reg[0]  = in_side;
    assign num[0]       = in_num_a;
    assign num[1]       = in_num_b;

    for (genvar g = 0; g <= QUOT_BITS + 1; g++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g+1] <= 1'b0;
            end else if (en) begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic zero_in, over_in;

        always_comb begin
            zero_in = (num[l] <= 0) || (in_side.sinv == '0);
            over_in = !zero_in &&
                      (num[l][WIDE-2:0] >= {{(WIDE-ROOT_BITS-2){1'b0}}, in_side.sinv, 1'b0});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[l][0] <= zero_in;
                over_reg[l][0] <= over_in;
                rem_reg[l][0]  <= num[l][30:0];
                quo_reg[l][0]  <= '0;
            end
        end

        for (genvar g = 0; g < QUOT_BITS; g++) begin : g_step
            logic        take;
            logic [30:0] sub;

            always_comb begin
                take = rem_reg[l][g] >= den_at(g);
                sub  = take ? rem_reg[l][g] - den_at(g) : rem_reg[l][g];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[l][g+1]  <= {sub[29:0], 1'b0};
                    quo_reg[l][g+1]  <= {quo_reg[l][g][QUOT_BITS-2:0], take};
                    zero_reg[l][g+1] <= zero_reg[l][g];
                    over_reg[l][g+1] <= over_reg[l][g];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (zero_reg[l][QUOT_BITS]) begin
                    w_reg[l] <= '0;
                end else if (over_reg[l][QUOT_BITS] || quo_reg[l][QUOT_BITS] > WEIGHT_ONE) begin
                    w_reg[l] <= WEIGHT_ONE;
                end else begin
                    w_reg[l] <= quo_reg[l][QUOT_BITS];
                end
            end
        end
    end

    assign out_valid = valid_reg[QUOT_BITS+2];
    assign out_side  = side_reg[QUOT_BITS+2];
    assign out_w_a   = w_reg[0];
    assign out_w_b   = w_reg[1];

endmodule

/* rtl/core/qslp_checker.sv */
// Port-level checker for quaternion_slerp and the bind that attaches it.
// Depends on qslp_pkg and the port list of quaternion_slerp.
module qslp_checker import qslp_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input comp_t                 m_out_x,
    input comp_t                 m_out_y,
    input comp_t                 m_out_z,
    input comp_t                 m_out_w,
    input logic                  m_linear_path
);

    // A result that was not taken stays on the port unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y) &&
        $stable(m_out_z) && $stable(m_out_w) && $stable(m_linear_path))
        else $error("result changed while stalled");

    // A blocked output stalls the input side as well.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // With the output free the pipeline always moves.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with free output");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quaternion_slerp qslp_checker u_qslp_checker (.*);
